FILE: hdl/nlc_pkg.sv
// ---------------------------------------------------------------------------
// nlc_pkg
// Types, constants and helper functions for the noise LFSR channel unit.
// ---------------------------------------------------------------------------
package nlc_pkg;

  localparam int LFSR_W  = 15;
  localparam int ACC_W   = 21;
  localparam int CYC_W   = 8;
  localparam int SHIFT_W = 4;
  localparam int CODE_W  = 3;
  localparam int BASE_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [SHIFT_W-1:0] MAX_CLOCK_SHIFT = 4'd13;
  localparam logic [15:0]        MAX_CYCLES      = 16'd255;
  localparam logic [LFSR_W-1:0]  LFSR_RELOAD     = 15'h7FFF;
  localparam int                 SHORT_BIT       = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SHIFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MODE   = 2'd2;

  typedef struct packed {
    logic [CYC_W-1:0] elapsed_cycles;
    logic             restart;
  } in_item_t;

  typedef struct packed {
    logic              level_high;
    logic [LFSR_W-1:0] lfsr_value;
  } out_item_t;

  // sequencer controls to the datapath
  typedef struct packed {
    logic load;
    logic restart;
    logic step;
  } nlc_ctrl_t;

  function automatic logic [BASE_W-1:0] base_divisor(input logic [CODE_W-1:0] code);
    logic [BASE_W-1:0] b;
    unique case (code)
      3'd0:    b = 7'd8;
      3'd1:    b = 7'd16;
      3'd2:    b = 7'd32;
      3'd3:    b = 7'd48;
      3'd4:    b = 7'd64;
      3'd5:    b = 7'd80;
      3'd6:    b = 7'd96;
      default: b = 7'd112;
    endcase
    return b;
  endfunction

  function automatic logic [ACC_W-1:0] period_of(input logic [CODE_W-1:0]  code,
                                                  input logic [SHIFT_W-1:0] shift);
    logic [SHIFT_W:0] amt;
    amt = {1'b0, shift} + 5'd1;
    return {{(ACC_W-BASE_W){1'b0}}, base_divisor(code)} << amt;
  endfunction

endpackage

FILE: hdl/nlc_lfsr.sv
// ---------------------------------------------------------------------------
// nlc_lfsr
// 15-bit shift register with reload and single-step feedback.
// ---------------------------------------------------------------------------
module nlc_lfsr (
  input  logic                      clk,
  input  logic                      rst,
  input  nlc_pkg::nlc_ctrl_t        ctrl,
  input  logic                      short_mode,
  output logic [nlc_pkg::LFSR_W-1:0] value
);
  import nlc_pkg::*;

  logic [LFSR_W-1:0] value_next;
  logic              fb;

  always_comb begin
    fb         = value[0] ^ value[1];
    value_next = {fb, value[LFSR_W-1:1]};
    if (short_mode) begin
      value_next[SHORT_BIT] = fb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= LFSR_RELOAD;
    end else if (ctrl.load && ctrl.restart) begin
      value <= LFSR_RELOAD;
    end else if (ctrl.step) begin
      value <= value_next;
    end
  end

endmodule

FILE: hdl/nlc_accum.sv
// ---------------------------------------------------------------------------
// nlc_accum
// Cycle accumulator with one shared compare/subtract unit against the period.
// ---------------------------------------------------------------------------
module nlc_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  nlc_pkg::nlc_ctrl_t         ctrl,
  input  logic [nlc_pkg::CYC_W-1:0]  cycles,
  input  logic [nlc_pkg::ACC_W-1:0]  period,
  output logic                       acc_ge
);
  import nlc_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] base;
  logic [ACC_W:0]   diff;

  // borrow out of the subtract doubles as the compare
  assign diff   = {1'b0, acc} - {1'b0, period};
  assign acc_ge = ~diff[ACC_W];
  assign base   = ctrl.restart ? '0 : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.load) begin
      acc <= base + {{(ACC_W-CYC_W){1'b0}}, cycles};
    end else if (ctrl.step) begin
      acc <= diff[ACC_W-1:0];
    end
  end

endmodule

FILE: hdl/noise_lfsr_channel_unit.sv
// An accepted item adds its cycles to the accumulator; in run the block then
// takes one step per cycle, one per whole period held, and hands the result to
// the output register when no whole period is left and the output is free.
// A new item is taken only while idle; one shared compare/subtract does the steps
// (a period shortened with cycles pending runs as many steps as the accumulator holds).
// Reset: synchronous; LFSR loads 0x7FFF, accumulator and configuration registers clear.
// ---------------------------------------------------------------------------
// noise_lfsr_channel_unit
// Noise channel: divider-clocked 15-bit LFSR stepped once per whole divider period.
// ---------------------------------------------------------------------------
module noise_lfsr_channel_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  nlc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output nlc_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nlc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nlc_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t             state;
  logic [SHIFT_W-1:0] clock_shift;
  logic [CODE_W-1:0]  divisor_code;
  logic               short_mode;
  nlc_ctrl_t          ctrl;
  logic               acc_ge;
  logic [ACC_W-1:0]   period;
  logic [CYC_W-1:0]   cycles;
  logic [LFSR_W-1:0]  lfsr;
  logic               accept;
  logic               out_free;
  logic               finish;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign finish    = (state == S_RUN) && !acc_ge && out_free;
  assign period    = period_of(divisor_code, clock_shift);
  assign cycles    = ({8'd0, in_data.elapsed_cycles} > MAX_CYCLES) ?
                     MAX_CYCLES[CYC_W-1:0] : in_data.elapsed_cycles;

  always_comb begin
    ctrl.load    = accept;
    ctrl.restart = in_data.restart;
    ctrl.step    = (state == S_RUN) && acc_ge;
  end

  nlc_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cycles (cycles),
    .period (period),
    .acc_ge (acc_ge)
  );

  nlc_lfsr u_lfsr (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .short_mode (short_mode),
    .value      (lfsr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_shift  <= '0;
      divisor_code <= '0;
      short_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLOCK_SHIFT:  clock_shift  <= (cfg_data > MAX_CLOCK_SHIFT) ?
                                          MAX_CLOCK_SHIFT : cfg_data;
        CFG_DIVISOR_CODE: divisor_code <= cfg_data[CODE_W-1:0];
        CFG_SHORT_MODE:   short_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          // all whole periods consumed and output free, hand the item to the output register
          if (finish) begin
            state               <= S_IDLE;
            out_data.level_high <= ~lfsr[0];
            out_data.lfsr_value <= lfsr;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block not busy after taking an item");

  a_run_while_ge: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && acc_ge) |=> (state == S_RUN && !out_valid) || $past(out_valid))
    else $error("left run with whole periods pending");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && !in_stall))
    else $error("finish did not present a result");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RUN))
    else $error("result appeared outside run");
`endif

endmodule

FILE: dv/noise_lfsr_channel_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// noise_lfsr_channel_unit_tb
// Self-checking bench for the noise channel LFSR: a queued driver and a
// monitor compare each output item with a local model of the divider and LFSR
// across several register settings and idle/stall mixes.
// ---------------------------------------------------------------------------
module noise_lfsr_channel_unit_tb;
  import nlc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  noise_lfsr_channel_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // local copy of the channel state and registers
  int unsigned div_base[8] = '{8, 16, 32, 48, 64, 80, 96, 112};
  logic [SHIFT_W-1:0] m_shift = '0;
  logic [CODE_W-1:0] m_div = '0;
  logic m_short = 1'b0;
  logic [LFSR_W-1:0] m_lfsr = LFSR_RELOAD;
  int unsigned m_acc = 0;

  // sender and receiver idle percentages per phase
  int unsigned send_mix[6] = '{0, 55, 0, 18, 0, 25};
  int unsigned recv_mix[6] = '{0, 0, 55, 18, 0, 25};

  in_item_t stim_q[$];
  out_item_t noise_sample_q[$];
  int unsigned n_queued = 0;
  int unsigned n_checked = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;

  task automatic advance_noise(input in_item_t it);
    int unsigned per;
    int unsigned n_steps;
    logic fb;
    if (it.restart) begin
      m_acc = 0;
      m_lfsr = LFSR_RELOAD;
    end
    per = div_base[m_div] << (m_shift + 1);
    m_acc = m_acc + it.elapsed_cycles;
    n_steps = m_acc / per;
    m_acc = m_acc % per;
    for (int unsigned i = 0; i < n_steps; i++) begin
      fb = m_lfsr[0] ^ m_lfsr[1];
      m_lfsr = {fb, m_lfsr[LFSR_W-1:1]};
      if (m_short) m_lfsr[SHORT_BIT] = fb;
    end
    noise_sample_q.push_back('{level_high: ~m_lfsr[0], lfsr_value: m_lfsr});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CLOCK_SHIFT: m_shift = (val > MAX_CLOCK_SHIFT) ? MAX_CLOCK_SHIFT : val;
      CFG_DIVISOR_CODE: m_div = val[CODE_W-1:0];
      CFG_SHORT_MODE: m_short = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_item(input int unsigned cyc, input logic rs);
    stim_q.push_back('{elapsed_cycles: cyc[CYC_W-1:0], restart: rs});
    n_queued++;
  endtask

  task automatic wait_drained;
    while (n_checked < n_queued) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_noise(in_data);
      if (!in_valid || !in_stall) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
          in_data <= stim_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (noise_sample_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, out_data);
          err_cnt++;
        end else begin
          want = noise_sample_q.pop_front();
          if (out_data.level_high !== want.level_high) begin
            $display("%0t: level_high mismatch, expected %b, actual %b", $time,
                     want.level_high, out_data.level_high);
            err_cnt++;
          end
          if (out_data.lfsr_value !== want.lfsr_value) begin
            $display("%0t: lfsr_value mismatch, expected %h, actual %h", $time,
                     want.lfsr_value, out_data.lfsr_value);
            err_cnt++;
          end
        end
        n_checked++;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("noise_lfsr_channel_unit_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned cyc;
    int unsigned sel;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: period 16
    queue_item(0, 1'b0);
    queue_item(255, 1'b0);
    queue_item(255, 1'b1);
    queue_item(1, 1'b0);
    queue_item(15, 1'b0);
    queue_item(16, 1'b0);
    queue_item(170, 1'b0);
    queue_item(85, 1'b1);
    queue_item(0, 1'b1);
    wait_drained();

    // oversized shift saturates, longest period, short sequence
    write_reg(CFG_CLOCK_SHIFT, 4'd15);
    write_reg(CFG_DIVISOR_CODE, 4'hF);
    write_reg(CFG_SHORT_MODE, 4'hF);
    write_reg(CFG_UNUSED, 4'hF);
    queue_item(255, 1'b0);
    queue_item(255, 1'b1);
    wait_drained();

    write_reg(CFG_CLOCK_SHIFT, 4'd14);
    write_reg(CFG_CLOCK_SHIFT, 4'd0);
    write_reg(CFG_DIVISOR_CODE, 4'hB);
    queue_item(255, 1'b0);
    queue_item(200, 1'b0);
    wait_drained();

    // fill the accumulator under a long period, then shorten it
    write_reg(CFG_CLOCK_SHIFT, 4'd3);
    write_reg(CFG_DIVISOR_CODE, 4'd7);
    write_reg(CFG_SHORT_MODE, 4'd0);
    queue_item(0, 1'b1);
    for (int i = 0; i < 7; i++) queue_item(255, 1'b0);
    wait_drained();
    write_reg(CFG_CLOCK_SHIFT, 4'd0);
    write_reg(CFG_DIVISOR_CODE, 4'd0);
    queue_item(0, 1'b0);
    queue_item(7, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        write_reg(CFG_CLOCK_SHIFT, 4'd0);
        write_reg(CFG_DIVISOR_CODE, 4'd0);
        write_reg(CFG_SHORT_MODE, 4'd0);
      end else begin
        if ($urandom_range(0, 5) == 0)
          write_reg(CFG_CLOCK_SHIFT, 4'($urandom_range(13, 15)));
        else
          write_reg(CFG_CLOCK_SHIFT, 4'($urandom_range(0, 2)));
        write_reg(CFG_DIVISOR_CODE, 4'($urandom_range(0, 15)));
        write_reg(CFG_SHORT_MODE, 4'($urandom_range(0, 15)));
      end
      send_pct = send_mix[ph];
      recv_pct = recv_mix[ph];
      if (ph == 4) hold_arm <= 1'b1;
      for (int i = 0; i < 150; i++) begin
        sel = $urandom_range(0, 9);
        cyc = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 255);
        queue_item(cyc, $urandom_range(0, 24) == 0);
      end
      wait_drained();
    end

    if (err_cnt == 0 && noise_sample_q.size() == 0) begin
      $display("noise_lfsr_channel_unit_tb passed");
    end else begin
      $display("noise_lfsr_channel_unit_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/nlc_pkg.sv
hdl/nlc_lfsr.sv
hdl/nlc_accum.sv
hdl/noise_lfsr_channel_unit.sv
dv/noise_lfsr_channel_unit_tb.sv
